[rtl/core/irp_pkg.sv]
// Shared types and constants for the interrupt router with pending lines.
// Holds the command codes, sequencer states and the result record.
// No dependencies.
package irp_pkg;

  localparam int CMD_W     = 3;
  localparam int IRQ_W     = 8;
  localparam int HANDLER_W = 4;
  localparam int OWNER_W   = 4;
  localparam int NBIT_W    = 6;
  localparam int DIRQ_W    = 6;
  localparam int LINE_DW   = HANDLER_W + NBIT_W;

  typedef enum logic [CMD_W-1:0] {
    CMD_ARRIVE     = 3'd0,
    CMD_REGISTER   = 3'd1,
    CMD_UNREGISTER = 3'd2,
    CMD_ACK        = 3'd3,
    CMD_GRANT      = 3'd4,
    CMD_REVOKE     = 3'd5
  } cmd_t;

  localparam logic [CMD_W-1:0] CMD_LAST = CMD_REVOKE;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LREAD,
    ST_LDATA,
    ST_EXEC,
    ST_SCAN,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic                 line_masked;
    logic                 made_pending;
    logic                 spurious;
    logic [NBIT_W-1:0]    deliver_bit;
    logic [DIRQ_W-1:0]    deliver_irq;
    logic [HANDLER_W-1:0] deliver_handler;
    logic                 delivered;
    logic                 status;
  } res_t;

endpackage

[rtl/core/irp_ram.sv]
// Single-port-write, single-port-read table with registered read data.
// Used for the per-line handler table and the per-handler slot table.
// No dependencies.
module irp_ram #(
  parameter int DW    = 10,
  parameter int DEPTH = 32,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port, hold data when idle
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/core/irp_ctrl.sv]
// Command sequencer of the interrupt router: line flags, owners, busy flags
// and the pending scan. Uses irp_pkg and two irp_ram tables.
// Produces one result record per item towards the output register.
module irp_ctrl
  import irp_pkg::*;
#(
  parameter int NUM_LINES    = 32,
  parameter int NUM_HANDLERS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [CMD_W-1:0]     in_cmd,
  input  logic [IRQ_W-1:0]     in_irq,
  input  logic [HANDLER_W-1:0] in_handler,
  input  logic [OWNER_W-1:0]   in_owner,
  input  logic [NBIT_W-1:0]    in_nbit,
  output logic                 res_valid,
  input  logic                 res_ready,
  output res_t                 res
);

  localparam int LW = $clog2(NUM_LINES);
  localparam int HW = $clog2(NUM_HANDLERS);
  localparam int SW = $clog2(NUM_LINES + 1);

  state_t state, state_next;

  // Latched item
  logic [CMD_W-1:0]     cmd_r;
  logic [IRQ_W-1:0]     irq_r;
  logic [HANDLER_W-1:0] h_r;
  logic [OWNER_W-1:0]   own_r;
  logic [NBIT_W-1:0]    nbit_r;
  logic                 bad_r;

  // Per-line and per-handler flags
  logic [NUM_LINES-1:0]    mask, mask_next;
  logic [NUM_LINES-1:0]    pend, pend_next;
  logic [NUM_LINES-1:0]    has, has_next;
  logic [NUM_HANDLERS-1:0] busy, busy_next;
  logic [OWNER_W-1:0]      owner [NUM_LINES];
  logic                    owner_we;
  logic [OWNER_W-1:0]      owner_wdata;

  // Scan counters
  logic [SW-1:0] scan_i, scan_i_next;
  logic          chk_v, chk_v_next;
  logic [LW-1:0] chk_idx, chk_idx_next;

  res_t res_r, res_next;

  // Table ports
  logic               lm_we, lm_re;
  logic [LW-1:0]      lm_raddr;
  logic [LINE_DW-1:0] lm_wdata, lm_q;
  logic               sm_we;
  logic [HW-1:0]      sm_waddr;
  logic [DIRQ_W-1:0]  sm_wdata, sm_q;

  logic                 in_bad;
  logic [LW-1:0]        li;
  logic [8:0]           hx, lhx;
  logic                 h_ok, lh_ok;
  logic [HW-1:0]        h_idx, lh_idx;
  logic [HANDLER_W-1:0] lq_h;
  logic [NBIT_W-1:0]    lq_nbit;
  logic                 owns, owner_match, slot_hit, found;

  assign in_bad   = ({1'b0, in_irq} >= 9'(NUM_LINES)) || (in_cmd > CMD_LAST);
  assign li       = irq_r[LW-1:0];
  assign hx       = 9'(h_r);
  assign h_ok     = hx < 9'(NUM_HANDLERS);
  assign h_idx    = hx[HW-1:0];
  assign lq_h     = lm_q[HANDLER_W-1:0];
  assign lq_nbit  = lm_q[LINE_DW-1:HANDLER_W];
  assign lhx      = 9'(lq_h);
  assign lh_ok    = lhx < 9'(NUM_HANDLERS);
  assign lh_idx   = lhx[HW-1:0];
  assign owns        = has[li] && (lq_h == h_r);
  assign owner_match = owner[li] == own_r;
  assign slot_hit    = busy[h_idx] && (sm_q == DIRQ_W'(li));
  assign found       = chk_v && pend[chk_idx] && has[chk_idx] && (lq_h == h_r);

  irp_ram #(.DW(LINE_DW), .DEPTH(NUM_LINES)) u_line_ram (
    .clk   (clk),
    .we    (lm_we),
    .waddr (li),
    .wdata (lm_wdata),
    .re    (lm_re),
    .raddr (lm_raddr),
    .rdata (lm_q)
  );

  irp_ram #(.DW(DIRQ_W), .DEPTH(NUM_HANDLERS)) u_slot_ram (
    .clk   (clk),
    .we    (sm_we),
    .waddr (sm_waddr),
    .wdata (sm_wdata),
    .re    (state == ST_LDATA),
    .raddr (h_idx),
    .rdata (sm_q)
  );

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state, table accesses and flag updates
  always_comb begin
    state_next   = state;
    mask_next    = mask;
    pend_next    = pend;
    has_next     = has;
    busy_next    = busy;
    owner_we     = 1'b0;
    owner_wdata  = own_r;
    scan_i_next  = scan_i;
    chk_v_next   = chk_v;
    chk_idx_next = chk_idx;
    res_next     = res_r;
    lm_we        = 1'b0;
    lm_wdata     = {nbit_r, h_r};
    lm_re        = 1'b0;
    lm_raddr     = li;
    sm_we        = 1'b0;
    sm_waddr     = h_idx;
    sm_wdata     = DIRQ_W'(li);
    in_ready     = (state == ST_IDLE);
    res_valid    = (state == ST_FIN);

    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          res_next        = '0;
          res_next.status = in_bad;
          state_next      = in_bad ? ST_FIN : ST_LREAD;
        end
      end
      ST_LREAD: begin
        lm_re      = 1'b1;
        state_next = ST_LDATA;
      end
      ST_LDATA: begin
        state_next = ST_EXEC;
      end
      ST_EXEC: begin
        state_next = ST_FIN;
        unique case (cmd_t'(cmd_r))
          CMD_ARRIVE: begin
            mask_next[li] = 1'b1;
            if (!has[li] || !lh_ok) begin
              res_next.spurious = 1'b1;
            end else if (busy[lh_idx]) begin
              pend_next[li]         = 1'b1;
              res_next.made_pending = 1'b1;
            end else begin
              busy_next[lh_idx]        = 1'b1;
              sm_we                    = 1'b1;
              sm_waddr                 = lh_idx;
              res_next.delivered       = 1'b1;
              res_next.deliver_handler = lq_h;
              res_next.deliver_irq     = DIRQ_W'(li);
              res_next.deliver_bit     = lq_nbit;
            end
          end
          CMD_REGISTER: begin
            if (owner_match && h_ok && !has[li]) begin
              has_next[li]  = 1'b1;
              mask_next[li] = 1'b0;
              lm_we         = 1'b1;
            end else begin
              res_next.status = 1'b1;
            end
          end
          CMD_UNREGISTER: begin
            if (owner_match && h_ok && owns) begin
              if (slot_hit) begin
                busy_next[h_idx] = 1'b0;
              end
              has_next[li]  = 1'b0;
              mask_next[li] = 1'b1;
              lm_we         = 1'b1;
              lm_wdata      = {{NBIT_W{1'b0}}, lq_h};
            end else begin
              res_next.status = 1'b1;
            end
          end
          CMD_ACK: begin
            if (h_ok && owns) begin
              if (slot_hit) begin
                busy_next[h_idx] = 1'b0;
              end
              mask_next[li] = 1'b0;
              scan_i_next   = '0;
              chk_v_next    = 1'b0;
              state_next    = ST_SCAN;
            end else begin
              res_next.status = 1'b1;
            end
          end
          CMD_GRANT: begin
            if (owner[li] != '0) begin
              res_next.status = 1'b1;
            end else begin
              owner_we = 1'b1;
            end
          end
          CMD_REVOKE: begin
            if (!owner_match) begin
              res_next.status = 1'b1;
            end else begin
              owner_we    = 1'b1;
              owner_wdata = '0;
            end
          end
          default: begin
            res_next.status = 1'b1;
          end
        endcase
      end
      ST_SCAN: begin
        // Check the entry read last cycle, read the next one
        if (found) begin
          pend_next[chk_idx]       = 1'b0;
          busy_next[h_idx]         = 1'b1;
          sm_we                    = 1'b1;
          sm_wdata                 = DIRQ_W'(chk_idx);
          res_next.delivered       = 1'b1;
          res_next.deliver_handler = h_r;
          res_next.deliver_irq     = DIRQ_W'(chk_idx);
          res_next.deliver_bit     = lq_nbit;
          state_next               = ST_FIN;
        end else if (scan_i != SW'(NUM_LINES)) begin
          lm_re        = 1'b1;
          lm_raddr     = scan_i[LW-1:0];
          chk_idx_next = scan_i[LW-1:0];
          chk_v_next   = 1'b1;
          scan_i_next  = scan_i + 1'b1;
        end else begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        if (res_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Result record; mask is read after the item has taken effect
  always_comb begin
    res             = res_r;
    res.line_masked = bad_r | mask[li];
  end

  // Latch the item on acceptance
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_r  <= in_cmd;
      irq_r  <= in_irq;
      h_r    <= in_handler;
      own_r  <= in_owner;
      nbit_r <= in_nbit;
      bad_r  <= in_bad;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    res_r   <= res_next;
    scan_i  <= scan_i_next;
    chk_idx <= chk_idx_next;
  end

  // Control flags and owners
  always_ff @(posedge clk) begin
    if (rst) begin
      mask  <= '1;
      pend  <= '0;
      has   <= '0;
      busy  <= '0;
      chk_v <= 1'b0;
      for (int k = 0; k < NUM_LINES; k++) begin
        owner[k] <= '0;
      end
    end else begin
      mask  <= mask_next;
      pend  <= pend_next;
      has   <= has_next;
      busy  <= busy_next;
      chk_v <= chk_v_next;
      if (owner_we) begin
        owner[li] <= owner_wdata;
      end
    end
  end

endmodule

[rtl/core/interrupt_router_with_pending.sv]
// Interrupt router with pending lines: routes lines to handlers, one in-flight slot per
// handler, and queues arrivals on busy handlers as pending. Takes one item at a time: an
// invalid item goes straight to its result, other commands first read the line table, and
// a successful acknowledge then runs the pending scan, which reads the per-line handler
// table through its single read port, one line per cycle, stopping at the first match.
// The result sits in an output register so the next item is taken while it waits.
// Uses irp_pkg and irp_ctrl.
module interrupt_router_with_pending
  import irp_pkg::*;
#(
  parameter int NUM_LINES    = 32,
  parameter int NUM_HANDLERS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,  // irq[7:0], handler[11:8], owner[15:12], notify_idx[21:16]
  input  logic [2:0]  s_tuser,  // cmd[2:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata   // status[0], delivered[1], deliver_handler[5:2],
                                // deliver_irq[11:6], deliver_bit[17:12], spurious[18],
                                // made_pending[19], line_masked[20]
);

  logic res_valid, res_ready;
  res_t res, out_r;

  irp_ctrl #(
    .NUM_LINES    (NUM_LINES),
    .NUM_HANDLERS (NUM_HANDLERS)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_cmd     (s_tuser),
    .in_irq     (s_tdata[7:0]),
    .in_handler (s_tdata[11:8]),
    .in_owner   (s_tdata[15:12]),
    .in_nbit    (s_tdata[21:16]),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res)
  );

  assign res_ready = !m_tvalid || m_tready;

  // Output register: load a finished result, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid && res_ready) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_r <= res;
    end
  end

  assign m_tdata = {3'b000, out_r};

endmodule

[rtl/core/irp_check.sv]
// Port-level checks for the interrupt router with pending lines.
// Bound to interrupt_router_with_pending; no package needed.
module irp_check (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata
);

  // Hold a stalled result
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // One item at a time: no acceptance right after one
  a_seq: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("item accepted while busy");

  // An invalid item never delivers and is never spurious or made pending
  a_bad: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[0] |-> !m_tdata[1] && !m_tdata[18] && !m_tdata[19])
    else $error("invalid item with side outcome");

  // Delivery, spurious and pending outcomes exclude one another
  a_excl: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> $onehot0({m_tdata[1], m_tdata[18], m_tdata[19]}))
    else $error("conflicting outcomes");

  // An arrival that is spurious or made pending leaves its line masked
  a_mask: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[18] || m_tdata[19]) |-> m_tdata[20])
    else $error("line not masked after arrival");

endmodule

bind interrupt_router_with_pending irp_check u_irp_check (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
